FILE: hdl/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds field widths, register and command codes, reset values and the
// controller command bundle. No dependencies.
package rrqs_pkg;

    // Default table depth; the top level may override it.
    localparam int MAX_SLOTS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int CMD_W     = 1;
    localparam int SLOT_W    = 6;
    localparam int BURST_W   = 16;
    localparam int SLICE_W   = 16;
    localparam int ELAPSED_W = 32;
    localparam int QUANTUM_W = 16;
    localparam int PCOUNT_W  = 7;

    // Stream payload widths, packed and padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_QUANTUM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = CFG_IDX_W'(1);

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);
    localparam logic [PCOUNT_W-1:0]  PCOUNT_RESET  = PCOUNT_W'(64);

    // Item kinds carried on the input tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_STEP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // write a burst length into the table
        logic start;   // search for the next slot and read its entry
        logic commit;  // charge the slice and load the result register
    } ctl_cmd_t;

endpackage

FILE: hdl/round_robin_quantum_scheduler.sv
// Round-robin scheduler with a time quantum: top level.
// Joins rrqs_ctrl and rrqs_datapath and packs the stream payloads.
// Depends on rrqs_pkg, rrqs_ctrl and rrqs_datapath.
//
// Usage:
//   Input stream (s_): s_tuser selects the item kind. A load writes a burst
//   length into a table slot and returns the scan position and elapsed time
//   to zero; it gives no result. A step picks the next slot with work left,
//   charges it up to one quantum and gives one result on the m_ stream.
//   Configuration channel: cfg_index 0 is the time quantum, 1 the process
//   count. Write it only while no item is in progress.
//   Sequence: a step first does the slot search and the table read, then the
//   read-modify-write of the entry and the result register load. The single
//   table read port and its read register split a step this way. No new item
//   is taken until the step in progress has committed its result.
//   A result waits in the output register while m_tready is low; loads are
//   still taken meanwhile, and a following step holds in its update cycle
//   until the waiting result has been transferred.
//   Reset: the quantum returns to 4, the process count to 64, every slot
//   reads as empty and the scan position and elapsed time are zero. There
//   is no clearing pass; the block takes items as soon as reset is released.
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // process_slot[5:0], burst_length[21:6]
    input  logic [CMD_W-1:0]      s_tuser,   // command[0]
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // served_process[5:0], slice_length[21:6],
                                             // elapsed_time[53:22]
    output logic                  m_tuser,   // all_done[0]
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t             cmd;
    logic [SLOT_W-1:0]    served_process;
    logic [SLICE_W-1:0]   slice_length;
    logic [ELAPSED_W-1:0] elapsed_time;

    // Controller.
    rrqs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .item_kind (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    // Datapath.
    rrqs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .process_slot   (s_tdata[SLOT_W-1:0]),
        .burst_length   (s_tdata[SLOT_W+BURST_W-1:SLOT_W]),
        .served_process (served_process),
        .slice_length   (slice_length),
        .elapsed_time   (elapsed_time),
        .all_done       (m_tuser)
    );

    // Result payload, padded to whole bytes.
    assign m_tdata = {(M_TDATA_W - SLOT_W - SLICE_W - ELAPSED_W)'(0),
                      elapsed_time, slice_length, served_process};

`ifndef SYNTHESIS
    // A step keeps the input side busy in the cycle after its transfer.
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_STEP)) |=> !s_tready)
        else $error("input accepted during a step update");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_LOAD) && !m_tvalid) |=> !m_tvalid)
        else $error("result produced by a load");

    // An all-done result carries no slot and no slice.
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (served_process == '0 && slice_length == '0))
        else $error("all-done result with a slot or slice");

    // A served slot is always charged some work.
    a_served_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (slice_length != '0))
        else $error("served slot with an empty slice");
`endif

endmodule

FILE: hdl/rrqs_ctrl.sv
// Controller of the round-robin quantum scheduler.
// Sequences input transfers, table updates and the result register's valid
// flag. Depends on rrqs_pkg.
module rrqs_ctrl
    import rrqs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] item_kind,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ctl_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Commands for the datapath.
    always_comb begin
        cmd        = '0;
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid && (item_kind == CMD_LOAD);
        cmd.start  = (state_reg == ST_IDLE) && s_tvalid && (item_kind == CMD_STEP);
        cmd.commit = (state_reg == ST_EXEC) && out_free;
    end

    // Next state and next result valid flag.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/rrqs_datapath.sv
// Datapath of the round-robin quantum scheduler.
// Holds the configuration registers, the work table with its non-zero mask,
// the slot search, the slice arithmetic and the result register. Uses rrqs_pkg.
module rrqs_datapath
    import rrqs_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SLOT_W-1:0]     process_slot,
    input  logic [BURST_W-1:0]    burst_length,
    output logic [SLOT_W-1:0]     served_process,
    output logic [SLICE_W-1:0]    slice_length,
    output logic [ELAPSED_W-1:0]  elapsed_time,
    output logic                  all_done
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    // Configuration registers.
    logic [QUANTUM_W-1:0] quantum_reg;
    logic [PCOUNT_W-1:0]  pcount_reg;

    // Scheduling state.
    logic [BURST_W-1:0]   rem_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] mask_reg;
    logic [IDX_W-1:0]     scan_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    // Step in flight.
    logic [IDX_W-1:0]     pos_reg;
    logic                 found_reg;
    logic [BURST_W-1:0]   rd_data_reg;

    // Result register.
    logic [SLOT_W-1:0]    out_served_reg;
    logic [SLICE_W-1:0]   out_slice_reg;
    logic [ELAPSED_W-1:0] out_elapsed_reg;
    logic                 out_done_reg;

    logic [31:0]          count_wide;
    logic [CNT_W-1:0]     count;
    logic [IDX_W-1:0]     start;
    logic [MAX_SLOTS-1:0] cand;
    logic [MAX_SLOTS-1:0] cand_hi;
    logic [IDX_W-1:0]     pos_hi;
    logic [IDX_W-1:0]     pos_lo;
    logic [IDX_W-1:0]     search_pos;
    logic                 search_found;
    logic [IDX_W-1:0]     rd_addr;
    logic                 load_ok;
    logic [IDX_W-1:0]     load_addr;
    logic [QUANTUM_W-1:0] quantum_eff;
    logic [SLICE_W-1:0]   slice;
    logic [BURST_W-1:0]   rem_new;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic [CNT_W-1:0]     pos_inc;
    logic [IDX_W-1:0]     scan_after;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RESET;
            pcount_reg  <= PCOUNT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TIME_QUANTUM) begin
                quantum_reg <= cfg_data;
            end else if (cfg_index == REG_PROCESS_COUNT) begin
                pcount_reg <= cfg_data[PCOUNT_W-1:0];
            end
        end
    end

    // Active slot count, limited to the table depth.
    assign count_wide = (32'(pcount_reg) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS)
                                                           : 32'(pcount_reg);
    assign count = CNT_W'(count_wide);
    assign start = (CNT_W'(scan_reg) < count) ? scan_reg : '0;

    // Cyclic search: the lowest busy slot at or after the start position,
    // otherwise the lowest busy slot overall.
    always_comb begin
        pos_hi = '0;
        pos_lo = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            cand[i]    = mask_reg[i] && (CNT_W'(i) < count);
            cand_hi[i] = cand[i] && (IDX_W'(i) >= start);
        end
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (cand_hi[i]) begin
                pos_hi = IDX_W'(i);
            end
            if (cand[i]) begin
                pos_lo = IDX_W'(i);
            end
        end
    end

    assign search_found = |cand;
    assign search_pos   = (|cand_hi) ? pos_hi : pos_lo;

    // Load address; slots beyond the table are not written.
    assign load_ok   = (32'(process_slot) < 32'(MAX_SLOTS));
    assign load_addr = IDX_W'(process_slot);
    assign rd_addr   = cmd.start ? search_pos : pos_reg;

    // Slice arithmetic on the entry read for the step in flight.
    assign quantum_eff = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign slice       = (rd_data_reg < quantum_eff) ? rd_data_reg : quantum_eff;
    assign rem_new     = rd_data_reg - slice;
    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(slice);
    assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
    assign pos_inc     = CNT_W'(pos_reg) + CNT_W'(1);
    assign scan_after  = (pos_inc >= count) ? '0 : IDX_W'(pos_inc);

    // Work table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            rem_mem[load_addr] <= burst_length;
        end else if (cmd.commit && found_reg) begin
            rem_mem[pos_reg] <= rem_new;
        end
        rd_data_reg <= rem_mem[rd_addr];
    end

    // Busy mask, scan position and elapsed total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            scan_reg    <= '0;
            elapsed_reg <= '0;
        end else if (cmd.load) begin
            if (load_ok) begin
                mask_reg[load_addr] <= (burst_length != '0);
            end
            scan_reg    <= '0;
            elapsed_reg <= '0;
        end else if (cmd.commit && found_reg) begin
            mask_reg[pos_reg] <= (rem_new != '0);
            scan_reg          <= scan_after;
            elapsed_reg       <= elapsed_sat;
        end
    end

    // Search result held for the update cycle.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pos_reg   <= search_pos;
            found_reg <= search_found;
        end
    end

    // Result register, loaded only when the controller commits.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_served_reg  <= found_reg ? SLOT_W'(pos_reg) : '0;
            out_slice_reg   <= found_reg ? slice : '0;
            out_elapsed_reg <= found_reg ? elapsed_sat : elapsed_reg;
            out_done_reg    <= !found_reg;
        end
    end

    assign served_process = out_served_reg;
    assign slice_length   = out_slice_reg;
    assign elapsed_time   = out_elapsed_reg;
    assign all_done       = out_done_reg;

endmodule
